// File: design/tlbpt_pkg.sv
// Shared types and fixed widths for the TLB and page-table translator.
package tlbpt_pkg;
	localparam int VA_W  = 16;
	localparam int PA_W  = 15;
	localparam int CNT_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic refresh;
		logic insert;
		logic invalidate;
	} tlb_op_t;

	typedef struct packed {
		logic take;
		logic refresh;
	} frame_op_t;
endpackage

// File: design/tlbpt_ram.sv
// Generic single-port RAM with registered read.
module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: design/tlbpt_tlb_cell.sv
// One TLB slot: valid, page, frame and replacement rank.
module tlbpt_tlb_cell #(
	parameter int PB  = 8,
	parameter int FB  = 7,
	parameter int TB  = 4,
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tlbpt_pkg::tlb_op_t      op,
	input  logic [PB-1:0]           page,
	input  logic [FB-1:0]           frame,
	input  logic [TB:0]             fill,
	input  logic [TB-1:0]           slot,
	input  logic [TB-1:0]           old_age,
	output logic                    match,
	output logic [FB-1:0]           frame_out,
	output logic [TB-1:0]           age_out
);
	import tlbpt_pkg::*;

	localparam logic [TB:0] IDX_W = (TB+1)'(IDX);

	logic          valid_q;
	logic [PB-1:0] page_q;
	logic [FB-1:0] frame_q;
	logic [TB-1:0] age_q;
	logic          used;
	logic          sel;

	assign used      = IDX_W < fill;
	assign sel       = slot == IDX_W[TB-1:0];
	assign match     = valid_q && (page_q == page);
	assign frame_out = frame_q;
	assign age_out   = age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (op.refresh) begin
				if (sel) begin
					age_q <= '0;
				end else if (used && age_q < old_age) begin
					age_q <= age_q + 1'b1;
				end
			end
			if (op.insert) begin
				if (sel) begin
					age_q <= '0;
				end else if (used) begin
					age_q <= age_q + 1'b1;
				end
			end
			// drop entries naming an evicted frame; a new fill wins
			if (op.invalidate && valid_q && frame_q == frame && !(op.insert && sel)) begin
				valid_q <= 1'b0;
			end
			if (op.insert && sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op.insert && sel) begin
			page_q  <= page;
			frame_q <= frame;
		end
	end
endmodule

// File: design/tlbpt_frame_cell.sv
// One physical frame: replacement rank among the allocated frames.
module tlbpt_frame_cell #(
	parameter int FB  = 7,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tlbpt_pkg::frame_op_t  op,
	input  logic [FB-1:0]         sel_frame,
	input  logic [FB:0]           count,
	input  logic [FB-1:0]         old_age,
	output logic [FB-1:0]         age_out
);
	import tlbpt_pkg::*;

	localparam logic [FB:0] IDX_W = (FB+1)'(IDX);

	logic [FB-1:0] age_q;
	logic          used;
	logic          sel;

	assign used    = IDX_W < count;
	assign sel     = sel_frame == IDX_W[FB-1:0];
	assign age_out = age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (op.take) begin
			if (sel) begin
				age_q <= '0;
			end else if (used) begin
				age_q <= age_q + 1'b1;
			end
		end else if (op.refresh) begin
			if (sel) begin
				age_q <= '0;
			end else if (used && age_q < old_age) begin
				age_q <= age_q + 1'b1;
			end
		end
	end
endmodule

// File: design/tlb_page_table_translator_unit.sv
// A request accepted while idle passes the lookup, decide and update steps, then
// strobes done. No new request is taken while busy; busy covers these steps,
// which share the page-table RAM port and the age cells.
// Results show on done for exactly one cycle; the receiver cannot stall.
// Reset (arst_n low) clears valid bits, ranks, fill counts and hit/fault totals
// at once; no clearing pass is needed.
module tlb_page_table_translator_unit #(
	parameter int OFFSET_BITS     = 8,
	parameter int VIRTUAL_PAGES   = 256,
	parameter int PHYSICAL_FRAMES = 128,
	parameter int TLB_ENTRIES     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tlbpt_pkg::VA_W-1:0]    virtual_address,
	input  logic                          policy_we,
	input  logic                          policy_wdata,
	output logic                          done,
	output logic [tlbpt_pkg::PA_W-1:0]    physical_address,
	output logic                          tlb_hit,
	output logic                          page_fault,
	output logic [tlbpt_pkg::CNT_W-1:0]   hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]   fault_total
);
	import tlbpt_pkg::*;

	localparam int PB = $clog2(VIRTUAL_PAGES);
	localparam int FB = $clog2(PHYSICAL_FRAMES);
	localparam int TB = $clog2(TLB_ENTRIES);
	localparam int OB = OFFSET_BITS;
	localparam logic [FB-1:0] F_MAX  = FB'(PHYSICAL_FRAMES - 1);
	localparam logic [TB-1:0] T_MAX  = TB'(TLB_ENTRIES - 1);
	localparam logic [FB:0]   F_FULL = (FB+1)'(PHYSICAL_FRAMES);
	localparam logic [TB:0]   T_FULL = (TB+1)'(TLB_ENTRIES);

	state_t state_q, state_d;

	logic                  policy_q;
	logic [PB-1:0]         page_q;
	logic [OB-1:0]         offset_q;
	logic [VIRTUAL_PAGES-1:0] page_valid_q;
	logic [FB:0]           frames_used_q;
	logic [TB:0]           tlb_fill_q;
	logic                  hit_q;
	logic [FB-1:0]         hit_frame_q;
	logic [TB-1:0]         hit_slot_q;
	logic [TB-1:0]         hit_age_q;
	logic                  pv_q;
	logic [FB-1:0]         fvict_q;
	logic [FB-1:0]         frame_q;
	logic                  fault_q;
	logic                  evict_q;
	logic [FB-1:0]         fold_q;
	logic [CNT_W-1:0]      hit_cnt_q;
	logic [CNT_W-1:0]      fault_cnt_q;
	logic                  done_q;

	logic [31:0]           va_ext;
	logic [31:0]           pa_ext;
	logic                  t_match [TLB_ENTRIES];
	logic [FB-1:0]         t_frame [TLB_ENTRIES];
	logic [TB-1:0]         t_age   [TLB_ENTRIES];
	logic [FB-1:0]         f_age   [PHYSICAL_FRAMES];
	logic                  hit_w;
	logic [FB-1:0]         hit_frame_w;
	logic [TB-1:0]         hit_slot_w;
	logic [TB-1:0]         hit_age_w;
	logic [FB-1:0]         fvict_w;
	logic [TB-1:0]         tvict_w;
	logic [FB-1:0]         frame_w;
	logic [FB-1:0]         fold_w;
	logic                  fault_w;
	logic                  ffull;
	logic                  tfull;
	tlb_op_t               t_op;
	frame_op_t             f_op;
	logic [TB-1:0]         t_slot;
	logic [TB-1:0]         ins_slot;
	logic [FB-1:0]         f_sel;
	logic [FB-1:0]         pf_rdata;
	logic                  pf_we;
	logic [PB-1:0]         own_rdata;
	logic                  own_we;
	logic [FB-1:0]         own_addr;

	assign va_ext   = {16'b0, virtual_address};
	assign ffull    = frames_used_q == F_FULL;
	assign tfull    = tlb_fill_q == T_FULL;
	assign ins_slot = tfull ? tvict_w : tlb_fill_q[TB-1:0];
	assign busy     = state_q != ST_IDLE;
	assign done     = done_q;

	// TLB row
	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_tlb
		tlbpt_tlb_cell #(.PB(PB), .FB(FB), .TB(TB), .IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (t_op),
			.page     (page_q),
			.frame    (frame_q),
			.fill     (tlb_fill_q),
			.slot     (t_slot),
			.old_age  (hit_age_q),
			.match    (t_match[i]),
			.frame_out(t_frame[i]),
			.age_out  (t_age[i])
		);
	end

	// frame row
	for (genvar i = 0; i < PHYSICAL_FRAMES; i++) begin : g_frame
		tlbpt_frame_cell #(.FB(FB), .IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (f_op),
			.sel_frame(f_sel),
			.count    (frames_used_q),
			.old_age  (fold_q),
			.age_out  (f_age[i])
		);
	end

	tlbpt_ram #(.WIDTH(FB), .DEPTH(VIRTUAL_PAGES)) u_page_frame (
		.clk  (clk),
		.we   (pf_we),
		.addr (page_q),
		.wdata(frame_q),
		.rdata(pf_rdata)
	);

	tlbpt_ram #(.WIDTH(PB), .DEPTH(PHYSICAL_FRAMES)) u_frame_owner (
		.clk  (clk),
		.we   (own_we),
		.addr (own_addr),
		.wdata(page_q),
		.rdata(own_rdata)
	);

	// one-hot reductions over the TLB row
	always_comb begin
		hit_w       = 1'b0;
		hit_frame_w = '0;
		hit_slot_w  = '0;
		hit_age_w   = '0;
		tvict_w     = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (t_match[i]) begin
				hit_w       = 1'b1;
				hit_frame_w = hit_frame_w | t_frame[i];
				hit_slot_w  = hit_slot_w | TB'(i);
				hit_age_w   = hit_age_w | t_age[i];
			end
			if (t_age[i] == T_MAX) begin
				tvict_w = tvict_w | TB'(i);
			end
		end
	end

	// ranks are distinct, so once full exactly one frame holds the top rank
	always_comb begin
		fvict_w = '0;
		fold_w  = '0;
		for (int i = 0; i < PHYSICAL_FRAMES; i++) begin
			if (f_age[i] == F_MAX) begin
				fvict_w = fvict_w | FB'(i);
			end
			if (frame_w == FB'(i)) begin
				fold_w = fold_w | f_age[i];
			end
		end
	end

	always_comb begin
		fault_w = !hit_q && !pv_q;
		if (hit_q) begin
			frame_w = hit_frame_q;
		end else if (pv_q) begin
			frame_w = pf_rdata;
		end else if (ffull) begin
			frame_w = fvict_q;
		end else begin
			frame_w = frames_used_q[FB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		t_op     = '0;
		f_op     = '0;
		t_slot   = hit_slot_q;
		f_sel    = frame_q;
		pf_we    = 1'b0;
		own_we   = 1'b0;
		own_addr = fvict_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d       = ST_UPDATE;
				t_op.refresh  = hit_q && policy_q;
				f_op.take     = fault_w;
				f_sel         = frame_w;
			end
			ST_UPDATE: begin
				state_d         = ST_IDLE;
				t_op.insert     = !hit_q;
				t_op.invalidate = evict_q;
				t_slot          = ins_slot;
				f_op.refresh    = policy_q && !fault_q;
				pf_we           = fault_q;
				own_we          = fault_q;
				own_addr        = frame_q;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= 1'b0;
			page_valid_q  <= '0;
			frames_used_q <= '0;
			tlb_fill_q    <= '0;
			hit_cnt_q     <= '0;
			fault_cnt_q   <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (policy_we) begin
				policy_q <= policy_wdata;
			end
			case (state_q)
				ST_DECIDE: begin
					if (hit_q && hit_cnt_q != '1) begin
						hit_cnt_q <= hit_cnt_q + 1'b1;
					end
					if (fault_w && fault_cnt_q != '1) begin
						fault_cnt_q <= fault_cnt_q + 1'b1;
					end
					if (fault_w && !ffull) begin
						frames_used_q <= frames_used_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (evict_q) begin
						page_valid_q[own_rdata] <= 1'b0;
					end
					if (fault_q) begin
						page_valid_q[page_q] <= 1'b1;
					end
					if (!hit_q && !tfull) begin
						tlb_fill_q <= tlb_fill_q + 1'b1;
					end
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign pa_ext = (32'(frame_q) << OB) | 32'(offset_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				page_q   <= va_ext[OB +: PB];
				offset_q <= virtual_address[OB-1:0];
			end
			ST_LOOK: begin
				hit_q       <= hit_w;
				hit_frame_q <= hit_frame_w;
				hit_slot_q  <= hit_slot_w;
				hit_age_q   <= hit_age_w;
				pv_q        <= page_valid_q[page_q];
				fvict_q     <= fvict_w;
			end
			ST_DECIDE: begin
				frame_q <= frame_w;
				fault_q <= fault_w;
				evict_q <= fault_w && ffull;
				fold_q  <= fold_w;
			end
			ST_UPDATE: begin
				physical_address <= pa_ext[PA_W-1:0];
				tlb_hit          <= hit_q;
				page_fault       <= fault_q;
				hit_total        <= hit_cnt_q;
				fault_total      <= fault_cnt_q;
			end
			default: begin
			end
		endcase
	end
endmodule

// File: design/tlbpt_checker.sv
// Port-level timing and result checks for the translator, bound to the top level.
module tlbpt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic tlb_hit,
	input logic page_fault
);
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result strobe not four cycles after request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done && tlb_hit |-> !page_fault)
		else $error("TLB hit reported together with page fault");
endmodule

bind tlb_page_table_translator_unit tlbpt_checker u_tlbpt_checker (.*);

// File: bench/tlb_page_table_translator_unit_tb.sv
// Self-checking bench for the TLB / page-table translator with FIFO and LRU replacement.
module tlb_page_table_translator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlbpt_pkg::*;

	localparam int PAGES     = 256;
	localparam int FRAMES    = 128;
	localparam int TLB_SLOTS = 16;
	localparam int CNT_MAX   = 65535;
	localparam int WATCHDOG  = 5000;
	localparam bit POL_FIFO  = 1'b0;
	localparam bit POL_LRU   = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [VA_W-1:0] virtual_address = '0;
	logic policy_we = 1'b0;
	logic policy_wdata = 1'b0;
	logic done;
	logic [PA_W-1:0] physical_address;
	logic tlb_hit;
	logic page_fault;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] fault_total;

	tlb_page_table_translator_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.virtual_address(virtual_address), .policy_we(policy_we),
		.policy_wdata(policy_wdata), .done(done),
		.physical_address(physical_address), .tlb_hit(tlb_hit),
		.page_fault(page_fault), .hit_total(hit_total), .fault_total(fault_total)
	);

	always #5 clk = ~clk;

	typedef struct packed {
		logic [PA_W-1:0]  pa;
		logic             hit;
		logic             fault;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] faults;
	} translation_t;

	translation_t translation_q[$];

	// translator shadow state
	bit cur_policy;
	bit pg_valid[PAGES];
	int pg_frame[PAGES];
	int owner_page[FRAMES];
	int frame_rank[FRAMES];
	int frames_taken;
	bit tlb_valid[TLB_SLOTS];
	int tlb_page[TLB_SLOTS];
	int tlb_frame[TLB_SLOTS];
	int tlb_rank[TLB_SLOTS];
	int tlb_count;
	int hit_cnt;
	int fault_cnt;

	int mismatches = 0;
	int checked = 0;
	int sent = 0;
	int idle_pct = 0;
	int quiet_cycles = 0;

	// Make idx newest among the first n slots of the TLB or frame ranks.
	function automatic void promote(bit in_tlb, int n, int idx);
		int old_rank;
		old_rank = in_tlb ? tlb_rank[idx] : frame_rank[idx];
		for (int i = 0; i < n; i++) begin
			if (i != idx) begin
				if (in_tlb && tlb_rank[i] < old_rank) tlb_rank[i]++;
				if (!in_tlb && frame_rank[i] < old_rank) frame_rank[i]++;
			end
		end
		if (in_tlb) tlb_rank[idx] = 0;
		else frame_rank[idx] = 0;
	endfunction

	function automatic int victim(bit in_tlb, int n);
		int best;
		best = 0;
		for (int i = 1; i < n; i++) begin
			if (in_tlb ? (tlb_rank[i] > tlb_rank[best]) :
			    (frame_rank[i] > frame_rank[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic void clear_shadow();
		cur_policy = POL_FIFO;
		foreach (pg_valid[i]) begin
			pg_valid[i] = 0;
			pg_frame[i] = 0;
		end
		foreach (frame_rank[i]) begin
			frame_rank[i] = 0;
			owner_page[i] = 0;
		end
		foreach (tlb_valid[i]) begin
			tlb_valid[i] = 0;
			tlb_page[i] = 0;
			tlb_frame[i] = 0;
			tlb_rank[i] = 0;
		end
		frames_taken = 0;
		tlb_count = 0;
		hit_cnt = 0;
		fault_cnt = 0;
	endfunction

	function automatic translation_t predict_translation(logic [VA_W-1:0] va);
		translation_t r;
		int page, frame, slot;
		bit hit, fault;
		page = int'(va[15:8]);
		frame = 0;
		hit = 0;
		fault = 0;
		for (int i = 0; i < tlb_count; i++) begin
			if (!hit && tlb_valid[i] && tlb_page[i] == page) begin
				hit = 1;
				frame = tlb_frame[i];
				if (cur_policy) promote(1'b1, tlb_count, i);
			end
		end
		if (hit) begin
			if (hit_cnt < CNT_MAX) hit_cnt++;
		end else begin
			if (pg_valid[page]) begin
				frame = pg_frame[page];
			end else begin
				fault = 1;
				if (fault_cnt < CNT_MAX) fault_cnt++;
				if (frames_taken < FRAMES) begin
					frame = frames_taken;
					frames_taken++;
					frame_rank[frame] = frames_taken - 1;
					promote(1'b0, frames_taken, frame);
				end else begin
					frame = victim(1'b0, FRAMES);
					promote(1'b0, FRAMES, frame);
					pg_valid[owner_page[frame]] = 0;
					for (int i = 0; i < tlb_count; i++)
						if (tlb_valid[i] && tlb_frame[i] == frame) tlb_valid[i] = 0;
				end
				pg_frame[page] = frame;
				pg_valid[page] = 1;
				owner_page[frame] = page;
			end
			// fill the TLB on a miss
			if (tlb_count < TLB_SLOTS) begin
				slot = tlb_count;
				tlb_count++;
				tlb_rank[slot] = tlb_count - 1;
				promote(1'b1, tlb_count, slot);
			end else begin
				slot = victim(1'b1, TLB_SLOTS);
				promote(1'b1, TLB_SLOTS, slot);
			end
			tlb_valid[slot] = 1;
			tlb_page[slot] = page;
			tlb_frame[slot] = frame;
		end
		if (cur_policy && !fault) promote(1'b0, frames_taken, frame);
		r.pa = PA_W'((frame << 8) | int'(va[7:0]));
		r.hit = hit;
		r.fault = fault;
		r.hits = CNT_W'(hit_cnt);
		r.faults = CNT_W'(fault_cnt);
		return r;
	endfunction

	// Hold start high until the request is taken; the caller lowers it with idle_gap or drain.
	task automatic send_request(logic [VA_W-1:0] va);
		start <= 1'b1;
		virtual_address <= va;
		do @(posedge clk); while (!(start && !busy));
		translation_q.push_back(predict_translation(va));
		sent++;
	endtask

	task automatic idle_gap();
		int n;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			n = $urandom_range(8, 1);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drain outstanding requests, then allow the block to settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (translation_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_policy(bit p);
		drain();
		policy_we <= 1'b1;
		policy_wdata <= p;
		@(posedge clk);
		policy_we <= 1'b0;
		cur_policy = p;
	endtask

	always @(posedge clk) begin
		translation_t want;
		if (done) begin
			if (translation_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result pa=%h", physical_address);
			end else begin
				want = translation_q.pop_front();
				checked++;
				if (physical_address !== want.pa || tlb_hit !== want.hit ||
				    page_fault !== want.fault || hit_total !== want.hits ||
				    fault_total !== want.faults) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp pa=%h hit=%b flt=%b ht=%0d ft=%0d",
							" got pa=%h hit=%b flt=%b ht=%0d ft=%0d"},
							want.pa, want.hit, want.fault, want.hits, want.faults,
							physical_address, tlb_hit, page_fault, hit_total,
							fault_total);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || translation_q.size() == 0 && !start)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("tlb_page_table_translator_unit test failed");
			$finish;
		end
	end

	task automatic test_directed();
		logic [VA_W-1:0] list[$];
		list = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0000, 16'hFFAA,
			16'h1234, 16'hAAAA, 16'h5555, 16'h1200, 16'h8001, 16'h7FFE};
		idle_pct = 0;
		foreach (list[i]) send_request(list[i]);
		write_policy(POL_LRU);
		foreach (list[i]) send_request(list[i] ^ 16'h0F0F);
		write_policy(POL_FIFO);
	endtask

	// Mostly a small working set so the TLB hits and refreshes; the rest roams all pages.
	task automatic test_random(int count, bit p, int pct);
		logic [VA_W-1:0] va;
		int base;
		write_policy(p);
		idle_pct = pct;
		base = $urandom_range(PAGES - 1);
		for (int i = 0; i < count; i++) begin
			va = VA_W'($urandom);
			if ($urandom_range(99) < 65) va[15:8] = 8'(base + $urandom_range(23));
			send_request(va);
			idle_gap();
			if (i == count / 2) begin
				start <= 1'b0;
				@(posedge clk);
				wait (translation_q.size() == 0);
			end
		end
		drain();
	endtask

	// A handful of pages revisited back to back under LRU: mostly TLB hits.
	task automatic test_hit_run();
		idle_pct = 0;
		write_policy(POL_LRU);
		repeat (30) send_request({8'h42 ^ 8'($urandom_range(3)), 8'($urandom)});
		drain();
	endtask

	// Step through pages under FIFO so faults evict frames and stale TLB entries.
	task automatic test_fault_run();
		int pg;
		idle_pct = 0;
		write_policy(POL_FIFO);
		pg = $urandom_range(PAGES - 1);
		repeat (40) begin
			send_request({8'(pg), 8'($urandom)});
			pg = (pg + 37) % PAGES;
		end
		drain();
	endtask

	initial begin
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(110, POL_FIFO, 0);
		test_random(110, POL_LRU, 79);
		test_random(100, POL_FIFO, 20);
		test_random(100, POL_LRU, 0);
		test_hit_run();
		test_fault_run();
		drain();
		$display("covered %0d requests (%0d checked): FIFO and LRU, idle gaps, eviction,",
			sent, checked);
		$display("policy switches between phases, TLB hit runs and fault runs");
		if (mismatches == 0 && translation_q.size() == 0)
			$display("tlb_page_table_translator_unit test passed");
		else
			$display("tlb_page_table_translator_unit test failed");
		$finish;
	end
endmodule
